>>> sv/hdlc_dfr_pkg.sv
// Shared types, codes and the CRC-16 byte update for the HDLC deframer.
package hdlc_dfr_pkg;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_R = 16'h8408;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_CRC_OK   = 3'd1,
    KIND_CRC_BAD  = 3'd2,
    KIND_ABORT    = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  address;
    logic [7:0]  control;
    logic [8:0]  payload_length;
    logic [15:0] received_check;
    logic [15:0] computed_check;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_R;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> sv/hdlc_dfr_out_buf.sv
// Output register with one skid entry for deframer results.
module hdlc_dfr_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  hdlc_dfr_pkg::result_t wr_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hdlc_dfr_pkg::result_t out_data
);

  logic                  skid_valid;
  hdlc_dfr_pkg::result_t skid_data;
  logic                  take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!wr_en) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= wr_en;
    end else if (wr_en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (wr_en) begin
        out_data <= wr_data;
      end
    end else if (!out_valid) begin
      if (wr_en) begin
        out_data <= wr_data;
      end
    end else if (wr_en) begin
      skid_data <= wr_data;
    end
  end

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !skid_valid)
    else $error("result written while skid entry full");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && !skid_valid && !wr_en) |=> !out_valid)
    else $error("output stays valid after last transaction taken");
`endif

endmodule

>>> sv/hdlc_byte_deframer_crc_check_top.sv
// HDLC byte deframer: unstuffing, FCS delay line, CRC-16 check, result output.
//
//   channel | signals                      | payload
//   --------+------------------------------+------------------------------------------
//   in      | in_valid, in_stall (driven)  | rx_byte
//   out     | out_valid, out_stall (input) | kind, payload_byte, address, control,
//           |                              | payload_length, received_check,
//           |                              | computed_check
//
// One byte per cycle while in_stall is low: each byte is decoded and the CRC updated
// in the accepting cycle; its result is registered into the output buffer.
// rst is synchronous and clears frame state, escape state and both output slots.
// in_stall rises only when the output register and its skid entry are both full.
module hdlc_byte_deframer_crc_check_top #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  address,
  output logic [7:0]  control,
  output logic [8:0]  payload_length,
  output logic [15:0] received_check,
  output logic [15:0] computed_check
);

  localparam int CW = $clog2(MAX_PAYLOAD + 3);
  localparam logic [CW-1:0] CNT_LIM = CW'(MAX_PAYLOAD + 2);
  localparam logic [CW-1:0] FCS_LEN = CW'(2);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_CTRL = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic        esc, esc_next;
  logic [7:0]  held_address, held_address_next;
  logic [7:0]  held_control, held_control_next;
  logic [7:0]  delay0, delay0_next;
  logic [7:0]  delay1, delay1_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0] crc, crc_next;

  logic        accept;
  logic        res_en;
  hdlc_dfr_pkg::result_t res, out_data;

  logic [7:0]    b;
  logic [CW-1:0] len_full;
  logic [15:0]   rx_fcs;

  assign accept   = in_valid && !in_stall;
  assign b        = esc ? (rx_byte ^ hdlc_dfr_pkg::ESC_XOR) : rx_byte;
  assign len_full = byte_count - FCS_LEN;
  assign rx_fcs   = {delay1, delay0};

  always_comb begin
    phase_next        = phase;
    esc_next          = esc;
    held_address_next = held_address;
    held_control_next = held_control;
    delay0_next       = delay0;
    delay1_next       = delay1;
    byte_count_next   = byte_count;
    crc_next          = crc;
    res_en            = 1'b0;
    res               = '0;
    res.kind          = hdlc_dfr_pkg::KIND_PAYLOAD;
    if (esc) begin
      esc_next = 1'b0;
    end
    if (!esc && rx_byte == hdlc_dfr_pkg::ESC_BYTE) begin
      esc_next = 1'b1;
    end else if (!esc && rx_byte == hdlc_dfr_pkg::FLAG_BYTE) begin
      if (phase == PH_IDLE) begin
        phase_next      = PH_ADDR;
        crc_next        = hdlc_dfr_pkg::CRC_INIT;
        byte_count_next = '0;
        delay0_next     = '0;
        delay1_next     = '0;
      end else if (phase == PH_DATA && byte_count >= FCS_LEN) begin
        res_en             = 1'b1;
        res.kind           = (rx_fcs == crc) ? hdlc_dfr_pkg::KIND_CRC_OK
                                             : hdlc_dfr_pkg::KIND_CRC_BAD;
        res.address        = held_address;
        res.control        = held_control;
        res.payload_length = 9'(len_full);
        res.received_check = rx_fcs;
        res.computed_check = crc;
        phase_next         = PH_IDLE;
      end else begin
        res_en     = 1'b1;
        res.kind   = hdlc_dfr_pkg::KIND_ABORT;
        phase_next = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_ADDR: begin
          held_address_next = b;
          crc_next          = hdlc_dfr_pkg::crc_byte(crc, b);
          phase_next        = PH_CTRL;
        end
        PH_CTRL: begin
          held_control_next = b;
          crc_next          = hdlc_dfr_pkg::crc_byte(crc, b);
          byte_count_next   = '0;
          phase_next        = PH_DATA;
        end
        PH_DATA: begin
          if (byte_count < FCS_LEN) begin
            // fill the FCS delay line
            if (byte_count[0]) begin
              delay1_next = b;
            end else begin
              delay0_next = b;
            end
            byte_count_next = byte_count + CW'(1);
          end else if (byte_count >= CNT_LIM) begin
            res_en             = 1'b1;
            res.kind           = hdlc_dfr_pkg::KIND_OVERFLOW;
            res.payload_length = 9'(len_full);
            phase_next         = PH_IDLE;
          end else begin
            // advance: oldest byte leaves as payload
            res_en           = 1'b1;
            res.payload_byte = delay0;
            crc_next         = hdlc_dfr_pkg::crc_byte(crc, delay0);
            delay0_next      = delay1;
            delay1_next      = b;
            byte_count_next  = byte_count + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      esc          <= 1'b0;
      held_address <= '0;
      held_control <= '0;
      delay0       <= '0;
      delay1       <= '0;
      byte_count   <= '0;
      crc          <= hdlc_dfr_pkg::CRC_INIT;
    end else if (accept) begin
      phase        <= phase_next;
      esc          <= esc_next;
      held_address <= held_address_next;
      held_control <= held_control_next;
      delay0       <= delay0_next;
      delay1       <= delay1_next;
      byte_count   <= byte_count_next;
      crc          <= crc_next;
    end
  end

  hdlc_dfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && res_en),
    .wr_data   (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind           = out_data.kind;
  assign payload_byte   = out_data.payload_byte;
  assign address        = out_data.address;
  assign control        = out_data.control;
  assign payload_length = out_data.payload_length;
  assign received_check = out_data.received_check;
  assign computed_check = out_data.computed_check;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_LIM)
    else $error("body byte count beyond overflow limit");
  a_result_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && res_en && res.kind != hdlc_dfr_pkg::KIND_PAYLOAD) |=> phase == PH_IDLE)
    else $error("frame end result without return to idle");
  a_payload_in_data: assert property (@(posedge clk) disable iff (rst)
    (accept && res_en && res.kind == hdlc_dfr_pkg::KIND_PAYLOAD) |=> phase == PH_DATA)
    else $error("payload transaction outside data phase");
`endif

endmodule

>>> tb/hdlc_byte_deframer_crc_check_top_tb.sv
// Self-checking testbench for the HDLC byte deframer with CRC-16 frame check.
module hdlc_byte_deframer_crc_check_top_tb;

  localparam int MAX_PAYLOAD = 256;
  localparam int HOLD_CYCLES = 60;
  localparam int ITEM_TARGET = 850;
  localparam hdlc_dfr_pkg::result_t ABORT_RES = '{hdlc_dfr_pkg::KIND_ABORT, 8'h00, 8'h00,
                                                  8'h00, 9'd0, 16'h0000, 16'h0000};

  typedef enum logic [1:0] {FR_IDLE, FR_ADDR, FR_CTRL, FR_BODY} frame_phase_t;

  typedef struct {
    logic [7:0]            line_byte;
    bit                    typed;
    hdlc_dfr_pkg::result_t res;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [7:0]  address;
  logic [7:0]  control;
  logic [8:0]  payload_length;
  logic [15:0] received_check;
  logic [15:0] computed_check;

  // Deframer state mirrored by the predictor
  frame_phase_t fr_phase = FR_IDLE;
  bit           esc_pending = 1'b0;
  logic [7:0]   held_addr = 8'h00;
  logic [7:0]   held_ctrl = 8'h00;
  logic [7:0]   fcs_pipe [2] = '{8'h00, 8'h00};
  int           body_cnt = 0;
  logic [15:0]  crc_acc = hdlc_dfr_pkg::CRC_INIT;

  hdlc_dfr_pkg::result_t expected_results[$];
  int      errors = 0;
  int      sent_items = 0;
  bit      quiet = 1'b0;
  int      hold_req = 0;
  int      hold_taken = 0;
  int      hold_left = 0;

  hdlc_byte_deframer_crc_check_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .payload_byte(payload_byte), .address(address), .control(control),
    .payload_length(payload_length), .received_check(received_check),
    .computed_check(computed_check)
  );

  always #5 clk = ~clk;

  // Reflected CRC-16, one bit per round, LSB first
  function automatic logic [15:0] fcs_update(input logic [15:0] c, input logic [7:0] d);
    bit fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) c = c ^ hdlc_dfr_pkg::CRC_POLY_R;
    end
    return c;
  endfunction

  // Advance the mirrored deframer by one line byte; return 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] raw,
                                      output hdlc_dfr_pkg::result_t r);
    logic [7:0]  b;
    bit          escaped;
    logic [15:0] rx_fcs;
    r = '0;
    b = raw;
    escaped = 1'b0;
    if (esc_pending) begin
      esc_pending = 1'b0;
      b = raw ^ hdlc_dfr_pkg::ESC_XOR;
      escaped = 1'b1;
    end else if (raw == hdlc_dfr_pkg::ESC_BYTE) begin
      esc_pending = 1'b1;
      return 1'b0;
    end
    if (!escaped && b == hdlc_dfr_pkg::FLAG_BYTE) begin
      if (fr_phase == FR_IDLE) begin
        fr_phase = FR_ADDR;
        crc_acc = hdlc_dfr_pkg::CRC_INIT;
        body_cnt = 0;
        fcs_pipe = '{8'h00, 8'h00};
        return 1'b0;
      end
      if (fr_phase == FR_BODY && body_cnt >= 2) begin
        rx_fcs = {fcs_pipe[1], fcs_pipe[0]};
        r.kind = (rx_fcs == crc_acc) ? hdlc_dfr_pkg::KIND_CRC_OK
                                     : hdlc_dfr_pkg::KIND_CRC_BAD;
        r.address = held_addr;
        r.control = held_ctrl;
        r.payload_length = 9'(body_cnt - 2);
        r.received_check = rx_fcs;
        r.computed_check = crc_acc;
        fr_phase = FR_IDLE;
        return 1'b1;
      end
      r.kind = hdlc_dfr_pkg::KIND_ABORT;
      fr_phase = FR_IDLE;
      return 1'b1;
    end
    case (fr_phase)
      FR_ADDR: begin
        held_addr = b;
        crc_acc = fcs_update(crc_acc, b);
        fr_phase = FR_CTRL;
      end
      FR_CTRL: begin
        held_ctrl = b;
        crc_acc = fcs_update(crc_acc, b);
        body_cnt = 0;
        fr_phase = FR_BODY;
      end
      FR_BODY: begin
        if (body_cnt < 2) begin
          fcs_pipe[body_cnt[0]] = b;
          body_cnt++;
        end else if (body_cnt - 2 >= MAX_PAYLOAD) begin
          r.kind = hdlc_dfr_pkg::KIND_OVERFLOW;
          r.payload_length = 9'(body_cnt - 2);
          fr_phase = FR_IDLE;
          return 1'b1;
        end else begin
          // oldest held byte leaves the FCS delay line as payload
          r.kind = hdlc_dfr_pkg::KIND_PAYLOAD;
          r.payload_byte = fcs_pipe[0];
          crc_acc = fcs_update(crc_acc, fcs_pipe[0]);
          fcs_pipe[0] = fcs_pipe[1];
          fcs_pipe[1] = b;
          body_cnt++;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic step_row_t row(input logic [7:0] b, input bit typed = 1'b0,
                                    input hdlc_dfr_pkg::result_t res = '0);
    step_row_t s;
    s.line_byte = b;
    s.typed = typed;
    s.res = res;
    return s;
  endfunction

  // Offer one line byte, hold it until the transaction completes, then predict
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input hdlc_dfr_pkg::result_t typed_res = '0);
    hdlc_dfr_pkg::result_t r;
    bit      has;
    while (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    has = deframe_byte(b, r);
    if (typed) expected_results.push_back(typed_res);
    else if (has) expected_results.push_back(r);
  endtask

  // Stuff one frame byte; escape reserved bytes always, others now and then
  task automatic send_data(input logic [7:0] x);
    if (x == hdlc_dfr_pkg::FLAG_BYTE || x == hdlc_dfr_pkg::ESC_BYTE ||
        $urandom_range(0, 19) == 0) begin
      send_byte(hdlc_dfr_pkg::ESC_BYTE);
      send_byte(x ^ hdlc_dfr_pkg::ESC_XOR);
    end else begin
      send_byte(x);
    end
  endtask

  task automatic send_frame(input int n, input bit good, input bit cut);
    logic [7:0]  fr[$];
    logic [15:0] c;
    int          stop;
    fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        fr.push_back($urandom_range(0, 1) ? hdlc_dfr_pkg::FLAG_BYTE : hdlc_dfr_pkg::ESC_BYTE);
      end else begin
        fr.push_back(8'($urandom_range(0, 255)));
      end
    end
    c = hdlc_dfr_pkg::CRC_INIT;
    foreach (fr[i]) c = fcs_update(c, fr[i]);
    if (!good) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    stop = cut ? $urandom_range(0, fr.size() - 1) : fr.size();
    send_byte(hdlc_dfr_pkg::FLAG_BYTE);
    for (int i = 0; i < stop; i++) send_data(fr[i]);
    send_byte(hdlc_dfr_pkg::FLAG_BYTE);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      errors++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_taken) begin
      out_stall <= 1'b1;
      hold_taken <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk) begin
    hdlc_dfr_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d", kind);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind));
        check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
        check_field("address", 16'(want.address), 16'(address));
        check_field("control", 16'(want.control), 16'(control));
        check_field("payload_length", 16'(want.payload_length), 16'(payload_length));
        check_field("received_check", want.received_check, received_check);
        check_field("computed_check", want.computed_check, computed_check);
      end
    end
  end

  initial begin
    step_row_t steps[$];
    int        k;
    int        n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    steps = '{
      row(hdlc_dfr_pkg::FLAG_BYTE),
      row(hdlc_dfr_pkg::FLAG_BYTE, 1'b1, ABORT_RES),  // flag where the address belongs
      row(8'h00),                                     // data while idle: dropped
      row(hdlc_dfr_pkg::ESC_BYTE),
      row(hdlc_dfr_pkg::FLAG_BYTE),                   // escaped flag while idle: dropped
      row(hdlc_dfr_pkg::FLAG_BYTE), row(8'hFF),
      row(hdlc_dfr_pkg::FLAG_BYTE, 1'b1, ABORT_RES),  // flag where the control belongs
      row(hdlc_dfr_pkg::FLAG_BYTE), row(8'h00), row(8'h03),
      row(hdlc_dfr_pkg::FLAG_BYTE, 1'b1, ABORT_RES),  // no body at all
      row(hdlc_dfr_pkg::FLAG_BYTE), row(8'hFF), row(8'hFF), row(8'h00),
      row(hdlc_dfr_pkg::FLAG_BYTE, 1'b1, ABORT_RES),  // one body byte only
      row(hdlc_dfr_pkg::FLAG_BYTE), row(8'h01), row(8'h03),
      row(hdlc_dfr_pkg::ESC_BYTE), row(8'h5E), row(hdlc_dfr_pkg::ESC_BYTE), row(8'h5D),
      row(8'hFF), row(8'h00), row(hdlc_dfr_pkg::FLAG_BYTE)
    };
    foreach (steps[i]) send_byte(steps[i].line_byte, steps[i].typed, steps[i].res);

    k = 0;
    while (sent_items < ITEM_TARGET) begin
      if (k == 6) hold_req++;
      if (k == 10) begin
        // drain everything before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      quiet = (k >= 7 && k < 10);
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      case (k)
        4: n = MAX_PAYLOAD;
        6: n = 30;
        9: n = MAX_PAYLOAD + 1 + $urandom_range(0, 2);
        default: n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      endcase
      send_frame(n, $urandom_range(0, 99) < 70, k > 10 && $urandom_range(0, 99) < 10);
      k++;
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> hdlc_byte_deframer_crc_check_top.f
sv/hdlc_dfr_pkg.sv
sv/hdlc_dfr_out_buf.sv
sv/hdlc_byte_deframer_crc_check_top.sv
tb/hdlc_byte_deframer_crc_check_top_tb.sv
